FILE: design/two_list_set_operations_core_macros.svh
// assertion helpers shared by the design files
`ifndef TWO_LIST_SET_OPERATIONS_CORE_MACROS_SVH
`define TWO_LIST_SET_OPERATIONS_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define TLSO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlso: same-cycle check failed");

// next-cycle implication, off during reset
`define TLSO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlso: next-cycle check failed");

`endif

FILE: design/tlso_pkg.sv
`default_nettype none

package tlso_pkg;

    // field widths
    localparam int WORD_W      = 32;
    localparam int REQ_W       = 2;
    localparam int SEC_W       = 3;
    localparam int MAX_LEN_DEF = 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN    = 2'd2;

    // section codes
    localparam logic [SEC_W-1:0] SEC_CAT     = 3'd0;
    localparam logic [SEC_W-1:0] SEC_COMMON  = 3'd1;
    localparam logic [SEC_W-1:0] SEC_A_ONLY  = 3'd2;
    localparam logic [SEC_W-1:0] SEC_B_ONLY  = 3'd3;
    localparam logic [SEC_W-1:0] SEC_A_ONLY2 = 3'd4;
    localparam logic [SEC_W-1:0] SEC_B_ONLY2 = 3'd5;

    // sequencer phases
    typedef enum logic [3:0] {
        P_IDLE,
        P_MATCH,
        P_CAT_A,
        P_CAT_B,
        P_COMMON,
        P_A_ONLY,
        P_B_ONLY,
        P_A_ONLY2,
        P_B_ONLY2,
        P_FLUSH
    } t_phase;

    // read stage info handed from the sequencer to the output stage
    typedef struct packed {
        logic             d_vld;
        logic             d_keep;
        logic [SEC_W-1:0] d_sec;
        logic             d_from_b;
        logic             flush;
        logic             ovf;
    } t_emit_ctl;

    // output stage status back to the sequencer
    typedef struct packed {
        logic adv;
    } t_out_stat;

    // section tag of an emitting phase
    function automatic logic [SEC_W-1:0] phase_sec(input t_phase ph);
        logic [SEC_W-1:0] sec;
        case (ph)
            P_COMMON:  sec = SEC_COMMON;
            P_A_ONLY:  sec = SEC_A_ONLY;
            P_B_ONLY:  sec = SEC_B_ONLY;
            P_A_ONLY2: sec = SEC_A_ONLY2;
            P_B_ONLY2: sec = SEC_B_ONLY2;
            default:   sec = SEC_CAT;
        endcase
        return sec;
    endfunction

    // phases that walk list b
    function automatic logic phase_from_b(input t_phase ph);
        logic fb;
        case (ph)
            P_CAT_B, P_B_ONLY, P_B_ONLY2: fb = 1'b1;
            default:                      fb = 1'b0;
        endcase
        return fb;
    endfunction

    // order of the emitting phases
    function automatic t_phase phase_next(input t_phase ph);
        t_phase nx;
        case (ph)
            P_CAT_A:   nx = P_CAT_B;
            P_CAT_B:   nx = P_COMMON;
            P_COMMON:  nx = P_A_ONLY;
            P_A_ONLY:  nx = P_B_ONLY;
            P_B_ONLY:  nx = P_A_ONLY2;
            P_A_ONLY2: nx = P_B_ONLY2;
            P_B_ONLY2: nx = P_FLUSH;
            default:   nx = P_IDLE;
        endcase
        return nx;
    endfunction

endpackage

`default_nettype wire

FILE: design/tlso_if.sv
`default_nettype none

// request channel
interface tlso_in_if import tlso_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

// result channel
interface tlso_out_if import tlso_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] value_res;
    logic [SEC_W-1:0]         section;
    logic                     is_last;
    logic                     overflow;

    modport source (output valid, output value_res, output section, output is_last,
                    output overflow, input ready);
    modport sink   (input valid, input value_res, input section, input is_last,
                    input overflow, output ready);
endinterface

`default_nettype wire

FILE: design/two_list_set_operations_core.sv
// Two-list set operations core.
// Request channel i_in: req_type load A, load B or run; value is the element to append.
// Result channel o_out: value_res, section tag, is_last on the final word of a run,
// and overflow when a load hit a full list since the previous run.
// Loads are taken one per cycle and write list A or B at its fill count; a load
// to a full list is dropped. A run first sweeps every (A, B) pair, one pair per
// cycle through the two list RAMs, to mark membership. It then walks the lists
// for the seven emitting passes (A and B for the concatenation, common, A-only,
// B-only and the two repeats), one RAM read per cycle while the output advances,
// then a drain step; at most one word leaves per cycle. Each word waits one stage
// so the final one can carry the last flag.
// New requests are held off until the run has been fully issued.
// A stalled receiver freezes the list walk; the word on the output holds and
// nothing is lost. Reset empties both lists and clears the dropped flag; the
// list RAMs themselves are not cleared.
`default_nettype none

module two_list_set_operations_core import tlso_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tlso_in_if.sink    i_in,
    tlso_out_if.source o_out
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    t_emit_ctl         ctl;
    t_out_stat         stat;
    logic              we_a;
    logic              we_b;
    logic [IDX_W-1:0]  waddr_a;
    logic [IDX_W-1:0]  waddr_b;
    logic [WORD_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
    logic [WORD_W-1:0] rdata_a;
    logic [WORD_W-1:0] rdata_b;

    // list A storage
    tlso_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_LEN)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (wdata),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    // list B storage
    tlso_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_LEN)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr_b),
        .i_wdata (wdata),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    // sequencer
    tlso_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .i_value    (i_in.value),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_ctl      (ctl),
        .o_we_a     (we_a),
        .o_we_b     (we_b),
        .o_waddr_a  (waddr_a),
        .o_waddr_b  (waddr_b),
        .o_wdata    (wdata),
        .o_raddr_a  (raddr_a),
        .o_raddr_b  (raddr_b),
        .i_rdata_a  (rdata_a),
        .i_rdata_b  (rdata_b)
    );

    // result staging
    tlso_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_stat    (stat),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

FILE: design/tlso_ram.sv
`default_nettype none

module tlso_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/tlso_ctrl.sv
`default_nettype none

`include "two_list_set_operations_core_macros.svh"

module tlso_ctrl import tlso_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF,
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [WORD_W-1:0] i_value,
    output logic                   o_in_ready,
    input  wire t_out_stat         i_stat,
    output t_emit_ctl              o_ctl,
    output logic                   o_we_a,
    output logic                   o_we_b,
    output logic [IDX_W-1:0]       o_waddr_a,
    output logic [IDX_W-1:0]       o_waddr_b,
    output logic [WORD_W-1:0]      o_wdata,
    output logic [IDX_W-1:0]       o_raddr_a,
    output logic [IDX_W-1:0]       o_raddr_b,
    input  wire logic [WORD_W-1:0] i_rdata_a,
    input  wire logic [WORD_W-1:0] i_rdata_b
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
    localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_LEN);

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]   r_cnt_b, n_cnt_b;
    logic               r_drop, n_drop;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_j, n_j;
    logic [CNT_W-1:0]   r_k, n_k;
    logic               r_m_vld, n_m_vld;
    logic [IDX_W-1:0]   r_m_i, n_m_i;
    logic [IDX_W-1:0]   r_m_j, n_m_j;
    logic [MAX_LEN-1:0] r_in_a, n_in_a;
    logic [MAX_LEN-1:0] r_in_b, n_in_b;
    logic               r_d_vld, n_d_vld;
    t_phase             r_d_phase, n_d_phase;
    logic [IDX_W-1:0]   r_d_idx, n_d_idx;

    logic             in_acc;
    logic             m_issue;
    logic             match_done;
    logic [CNT_W-1:0] emit_len;
    logic             emit_issue;
    logic             emit_end;
    logic             d_keep;

    assign in_acc     = i_in_valid && o_in_ready;
    assign m_issue    = (r_cnt_a != '0) && (r_cnt_b != '0);
    assign match_done = !m_issue || ((r_i + ONE_C == r_cnt_a) && (r_j + ONE_C == r_cnt_b));
    assign emit_len   = phase_from_b(r_phase) ? r_cnt_b : r_cnt_a;
    assign emit_issue = r_k < emit_len;
    assign emit_end   = (r_k + ONE_C) >= emit_len;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            P_IDLE: begin
                if (in_acc && i_req_type == REQ_RUN) begin
                    n_phase = P_MATCH;
                end
            end
            P_MATCH: begin
                if (match_done) begin
                    n_phase = P_CAT_A;
                end
            end
            P_FLUSH: begin
                if (i_stat.adv && !r_d_vld) begin
                    n_phase = P_IDLE;
                end
            end
            default: begin
                if (i_stat.adv && emit_end) begin
                    n_phase = phase_next(r_phase);
                end
            end
        endcase
    end

    // loads, membership pass and list walk
    always_comb begin
        o_in_ready = 1'b0;
        o_we_a     = 1'b0;
        o_we_b     = 1'b0;
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_drop     = r_drop;
        n_ovf      = r_ovf;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_m_vld    = 1'b0;
        n_m_i      = r_i[IDX_W-1:0];
        n_m_j      = r_j[IDX_W-1:0];
        n_in_a     = r_in_a;
        n_in_b     = r_in_b;
        n_d_vld    = r_d_vld;
        n_d_phase  = r_d_phase;
        n_d_idx    = r_d_idx;
        case (r_phase)
            P_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    case (i_req_type)
                        REQ_LOAD_A: begin
                            if (r_cnt_a < LEN_MAX) begin
                                o_we_a  = 1'b1;
                                n_cnt_a = r_cnt_a + ONE_C;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        REQ_LOAD_B: begin
                            if (r_cnt_b < LEN_MAX) begin
                                o_we_b  = 1'b1;
                                n_cnt_b = r_cnt_b + ONE_C;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        REQ_RUN: begin
                            n_ovf  = r_drop;
                            n_drop = 1'b0;
                            n_in_a = '0;
                            n_in_b = '0;
                            n_i    = '0;
                            n_j    = '0;
                            n_k    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            P_MATCH: begin
                n_m_vld = m_issue;
                if (r_j + ONE_C >= r_cnt_b) begin
                    n_j = '0;
                    n_i = (r_i + ONE_C >= r_cnt_a) ? '0 : r_i + ONE_C;
                end else begin
                    n_j = r_j + ONE_C;
                end
            end
            P_FLUSH: begin
                if (i_stat.adv) begin
                    n_d_vld = 1'b0;
                    if (!r_d_vld) begin
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                    end
                end
            end
            default: begin
                if (i_stat.adv) begin
                    n_d_vld   = emit_issue;
                    n_d_phase = r_phase;
                    n_d_idx   = r_k[IDX_W-1:0];
                    n_k       = emit_end ? '0 : r_k + ONE_C;
                end
            end
        endcase
        // pair compare in the cycle after the reads are issued
        if (r_m_vld && i_rdata_a == i_rdata_b) begin
            n_in_b[r_m_i] = 1'b1;
            n_in_a[r_m_j] = 1'b1;
        end
    end

    // write port follows the fill counts
    assign o_waddr_a = r_cnt_a[IDX_W-1:0];
    assign o_waddr_b = r_cnt_b[IDX_W-1:0];
    assign o_wdata   = i_value;

    // read addresses; a stalled word keeps its entry on the ram output
    always_comb begin
        if (r_phase == P_MATCH) begin
            o_raddr_a = r_i[IDX_W-1:0];
            o_raddr_b = r_j[IDX_W-1:0];
        end else if (!i_stat.adv && r_d_vld) begin
            o_raddr_a = r_d_idx;
            o_raddr_b = r_d_idx;
        end else begin
            o_raddr_a = r_k[IDX_W-1:0];
            o_raddr_b = r_k[IDX_W-1:0];
        end
    end

    // membership filter for the word on the ram output
    always_comb begin
        case (r_d_phase)
            P_COMMON:            d_keep = r_in_b[r_d_idx];
            P_A_ONLY, P_A_ONLY2: d_keep = !r_in_b[r_d_idx];
            P_B_ONLY, P_B_ONLY2: d_keep = !r_in_a[r_d_idx];
            default:             d_keep = 1'b1;
        endcase
    end

    assign o_ctl.d_vld    = r_d_vld;
    assign o_ctl.d_keep   = d_keep;
    assign o_ctl.d_sec    = phase_sec(r_d_phase);
    assign o_ctl.d_from_b = phase_from_b(r_d_phase);
    assign o_ctl.flush    = (r_phase == P_FLUSH);
    assign o_ctl.ovf      = r_ovf;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_drop  <= 1'b0;
            r_m_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_k     <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_drop  <= n_drop;
            r_m_vld <= n_m_vld;
            r_d_vld <= n_d_vld;
            r_k     <= n_k;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_ovf     <= n_ovf;
        r_i       <= n_i;
        r_j       <= n_j;
        r_m_i     <= n_m_i;
        r_m_j     <= n_m_j;
        r_in_a    <= n_in_a;
        r_in_b    <= n_in_b;
        r_d_phase <= n_d_phase;
        r_d_idx   <= n_d_idx;
    end

    `TLSO_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt_a <= LEN_MAX && r_cnt_b <= LEN_MAX)
    `TLSO_ASSERT_IMP(a_word_phase, i_clk, i_rst_n, r_d_vld, r_phase != P_IDLE && r_phase != P_MATCH)
    `TLSO_ASSERT_NXT(a_match_cmp, i_clk, i_rst_n, r_phase == P_MATCH && m_issue, r_m_vld)

endmodule

`default_nettype wire

FILE: design/tlso_out.sv
`default_nettype none

`include "two_list_set_operations_core_macros.svh"

module tlso_out import tlso_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_emit_ctl         i_ctl,
    input  wire logic [WORD_W-1:0] i_rdata_a,
    input  wire logic [WORD_W-1:0] i_rdata_b,
    output t_out_stat              o_stat,
    tlso_out_if.source             o_out
);

    logic               r_p_vld, n_p_vld;
    logic [WORD_W-1:0]  r_p_val, n_p_val;
    logic [SEC_W-1:0]   r_p_sec, n_p_sec;
    logic               r_p_ovf, n_p_ovf;
    logic               r_o_vld, n_o_vld;
    logic [WORD_W-1:0]  r_o_val, n_o_val;
    logic [SEC_W-1:0]   r_o_sec, n_o_sec;
    logic               r_o_last, n_o_last;
    logic               r_o_ovf, n_o_ovf;

    logic adv;
    logic take_word;
    logic push_last;

    assign adv       = !r_o_vld || o_out.ready;
    assign take_word = i_ctl.d_vld && i_ctl.d_keep;
    assign push_last = i_ctl.flush && !i_ctl.d_vld && r_p_vld;

    // one-deep hold so the final word of a run can carry the last flag
    always_comb begin
        n_p_vld  = r_p_vld;
        n_p_val  = r_p_val;
        n_p_sec  = r_p_sec;
        n_p_ovf  = r_p_ovf;
        n_o_vld  = r_o_vld;
        n_o_val  = r_o_val;
        n_o_sec  = r_o_sec;
        n_o_last = r_o_last;
        n_o_ovf  = r_o_ovf;
        if (adv) begin
            n_o_vld = 1'b0;
            if (take_word) begin
                if (r_p_vld) begin
                    n_o_vld  = 1'b1;
                    n_o_val  = r_p_val;
                    n_o_sec  = r_p_sec;
                    n_o_last = 1'b0;
                    n_o_ovf  = r_p_ovf;
                end
                n_p_vld = 1'b1;
                n_p_val = i_ctl.d_from_b ? i_rdata_b : i_rdata_a;
                n_p_sec = i_ctl.d_sec;
                n_p_ovf = i_ctl.ovf;
            end else if (push_last) begin
                n_o_vld  = 1'b1;
                n_o_val  = r_p_val;
                n_o_sec  = r_p_sec;
                n_o_last = 1'b1;
                n_o_ovf  = r_p_ovf;
                n_p_vld  = 1'b0;
            end
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_p_vld <= n_p_vld;
            r_o_vld <= n_o_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_p_val  <= n_p_val;
        r_p_sec  <= n_p_sec;
        r_p_ovf  <= n_p_ovf;
        r_o_val  <= n_o_val;
        r_o_sec  <= n_o_sec;
        r_o_last <= n_o_last;
        r_o_ovf  <= n_o_ovf;
    end

    assign o_stat.adv      = adv;

    assign o_out.valid     = r_o_vld;
    assign o_out.value_res = r_o_val;
    assign o_out.section   = r_o_sec;
    assign o_out.is_last   = r_o_last;
    assign o_out.overflow  = r_o_ovf;

    `TLSO_ASSERT_IMP(a_last_drains, i_clk, i_rst_n, r_o_vld && r_o_last, !r_p_vld)
    `TLSO_ASSERT_NXT(a_last_push, i_clk, i_rst_n, adv && push_last, r_o_vld && r_o_last)

endmodule

`default_nettype wire

FILE: test/two_list_set_operations_core_tb.sv
`default_nettype none

module two_list_set_operations_core_tb;
    import tlso_pkg::*;

    localparam int MAX_LEN = MAX_LEN_DEF;
    // request code the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 100;

    // one result word as the block emits it
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [SEC_W-1:0]         section;
        logic                     is_last;
        logic                     overflow;
    } result_word_t;

    logic i_clk;
    logic i_rst_n = 1'b0;

    tlso_in_if  in_if();
    tlso_out_if out_if();

    two_list_set_operations_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // predicted list contents and flags
    logic signed [WORD_W-1:0] lst_a [MAX_LEN];
    logic signed [WORD_W-1:0] lst_b [MAX_LEN];
    int  cnt_a = 0;
    int  cnt_b = 0;
    bit  dropped = 1'b0;

    result_word_t pending_results[$];

    int fail_count = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    bit hold_request = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // membership of a value in list a or list b
    function automatic bit in_list(input logic signed [WORD_W-1:0] v, input bit in_b);
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < (in_b ? cnt_b : cnt_a); k++) begin
            if ((in_b ? lst_b[k] : lst_a[k]) == v) hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic push_word(input logic signed [WORD_W-1:0] v, input logic [SEC_W-1:0] sec,
                             input bit ovf);
        result_word_t w;
        w.value    = v;
        w.section  = sec;
        w.is_last  = 1'b0;
        w.overflow = ovf;
        pending_results.push_back(w);
    endtask

    // words of one list whose membership in the other list equals want_in
    task automatic push_filtered(input bit src_b, input bit want_in,
                                 input logic [SEC_W-1:0] sec, input bit ovf);
        logic signed [WORD_W-1:0] v;
        for (int k = 0; k < (src_b ? cnt_b : cnt_a); k++) begin
            v = src_b ? lst_b[k] : lst_a[k];
            if (in_list(v, !src_b) == want_in) push_word(v, sec, ovf);
        end
    endtask

    // update list state for one accepted request and queue the words it causes
    task automatic apply_request(input logic [REQ_W-1:0] req,
                                 input logic signed [WORD_W-1:0] val);
        int first;
        bit ovf;
        case (req)
            REQ_LOAD_A: begin
                if (cnt_a < MAX_LEN) begin
                    lst_a[cnt_a] = val;
                    cnt_a++;
                end else begin
                    dropped = 1'b1;
                end
            end
            REQ_LOAD_B: begin
                if (cnt_b < MAX_LEN) begin
                    lst_b[cnt_b] = val;
                    cnt_b++;
                end else begin
                    dropped = 1'b1;
                end
            end
            REQ_RUN: begin
                first = pending_results.size();
                ovf = dropped;
                for (int k = 0; k < cnt_a; k++) push_word(lst_a[k], SEC_CAT, ovf);
                for (int k = 0; k < cnt_b; k++) push_word(lst_b[k], SEC_CAT, ovf);
                push_filtered(1'b0, 1'b1, SEC_COMMON, ovf);
                push_filtered(1'b0, 1'b0, SEC_A_ONLY, ovf);
                push_filtered(1'b1, 1'b0, SEC_B_ONLY, ovf);
                push_filtered(1'b0, 1'b0, SEC_A_ONLY2, ovf);
                push_filtered(1'b1, 1'b0, SEC_B_ONLY2, ovf);
                if (pending_results.size() > first)
                    pending_results[pending_results.size() - 1].is_last = 1'b1;
                cnt_a = 0;
                cnt_b = 0;
                dropped = 1'b0;
            end
            default: ;
        endcase
    endtask

    // check result words and predict on accepted requests
    always @(posedge i_clk) begin
        result_word_t exp_w;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result word: value_res %0d section %0d",
                           out_if.value_res, out_if.section);
                    fail_count++;
                end else begin
                    exp_w = pending_results.pop_front();
                    if (out_if.value_res !== exp_w.value) begin
                        $error("value_res: expected %0d, got %0d", exp_w.value, out_if.value_res);
                        fail_count++;
                    end
                    if (out_if.section !== exp_w.section) begin
                        $error("section: expected %0d, got %0d", exp_w.section, out_if.section);
                        fail_count++;
                    end
                    if (out_if.is_last !== exp_w.is_last) begin
                        $error("is_last: expected %0d, got %0d", exp_w.is_last, out_if.is_last);
                        fail_count++;
                    end
                    if (out_if.overflow !== exp_w.overflow) begin
                        $error("overflow: expected %0d, got %0d",
                               exp_w.overflow, out_if.overflow);
                        fail_count++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) apply_request(in_if.req_type, in_if.value);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (recv_idle_on) begin
                out_if.ready <= ($urandom_range(99) >= 24);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // offer one request word; called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [REQ_W-1:0] req, input logic signed [WORD_W-1:0] val);
        while (send_idle_on && $urandom_range(99) < 24) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.req_type <= req;
        in_if.value    <= val;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (req != REQ_UNUSED) items_sent++;
        @(negedge i_clk);
    endtask

    // stop offering and wait for every predicted word
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_value();
        logic signed [WORD_W-1:0] v;
        case ($urandom_range(7))
            0, 1, 2, 3: v = int'($urandom_range(6)) - 3;
            4: begin
                case ($urandom_range(3))
                    0: v = 32'sh80000000;
                    1: v = 32'sh7fffffff;
                    2: v = -1;
                    default: v = 0;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // mostly short lists, some long ones up to full, a few past full
    function automatic int pick_len();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 8) n = 0;
        else if (r < 80) n = $urandom_range(4, 1);
        else if (r < 93) n = $urandom_range(MAX_LEN, 5);
        else n = $urandom_range(MAX_LEN + 2, MAX_LEN + 1);
        return n;
    endfunction

    // interleaved loads of both lists with some noise, then a run
    task automatic random_batch();
        int na;
        int nb;
        na = pick_len();
        nb = pick_len();
        while (na + nb > 0) begin
            if ($urandom_range(29) == 0) send_word(REQ_UNUSED, $urandom);
            if (na > 0 && (nb == 0 || $urandom_range(1))) begin
                send_word(REQ_LOAD_A, pick_value());
                na--;
            end else begin
                send_word(REQ_LOAD_B, pick_value());
                nb--;
            end
        end
        send_word(REQ_RUN, $urandom);
    endtask

    task automatic test_empty_run();
        send_word(REQ_RUN, 32'sh7fffffff);
        drain_results();
    endtask

    // extreme values, duplicates, a full list with a dropped load, ignored code
    task automatic test_extremes_overflow();
        send_word(REQ_LOAD_A, 32'sh80000000);
        send_word(REQ_LOAD_B, 32'sh7fffffff);
        send_word(REQ_LOAD_A, 32'sh7fffffff);
        send_word(REQ_LOAD_A, -1);
        send_word(REQ_LOAD_B, 0);
        send_word(REQ_LOAD_A, 0);
        send_word(REQ_LOAD_A, 32'sh7fffffff);
        send_word(REQ_LOAD_A, 1);
        send_word(REQ_UNUSED, -1);
        send_word(REQ_LOAD_A, 32'sh55555555);
        send_word(REQ_LOAD_A, 32'shaaaaaaaa);
        send_word(REQ_LOAD_B, 32'sh2aaaaaaa);
        send_word(REQ_LOAD_A, 42);
        send_word(REQ_RUN, 32'sh80000000);
        drain_results();
    endtask

    // only list b loaded, with a duplicate
    task automatic test_single_list();
        send_word(REQ_LOAD_B, -7);
        send_word(REQ_LOAD_B, -7);
        send_word(REQ_RUN, 0);
        drain_results();
    endtask

    // dropped flag cleared by the previous run
    task automatic test_flag_clear();
        send_word(REQ_LOAD_A, 3);
        send_word(REQ_RUN, -1);
        drain_results();
    endtask

    task automatic test_random_runs();
        int start;
        start = items_sent;
        while (items_sent - start < 100) random_batch();
        drain_results();
    endtask

    task automatic test_no_idle_stretch();
        int start;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        start = items_sent;
        while (items_sent - start < 60) random_batch();
        drain_results();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // receiver holds off while full lists and two runs are offered
    task automatic test_back_pressure();
        hold_request = 1'b1;
        for (int k = 0; k < MAX_LEN; k++) send_word(REQ_LOAD_A, int'($urandom_range(9)));
        for (int k = 0; k < MAX_LEN; k++) send_word(REQ_LOAD_B, int'($urandom_range(9)));
        send_word(REQ_RUN, $urandom);
        for (int k = 0; k < 6; k++) send_word(REQ_LOAD_A, pick_value());
        for (int k = 0; k < 3; k++) send_word(REQ_LOAD_B, pick_value());
        send_word(REQ_RUN, $urandom);
        drain_results();
    endtask

    // stimulus sequence
    initial begin
        in_if.valid    = 1'b0;
        in_if.req_type = REQ_LOAD_A;
        in_if.value    = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_run();
        test_extremes_overflow();
        test_single_list();
        test_flag_clear();
        test_random_runs();
        test_no_idle_stretch();
        test_back_pressure();
        test_random_runs();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
